>>> src/tlps_pkg.sv
// Shared types and constants of the three-level priority scheduler.
`default_nettype none
package tlps_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int NUM_LEVELS  = 3;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] FUNC_INIT    = 2'd0;
    localparam logic [1:0] FUNC_CREATE  = 2'd1;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd2;
    localparam logic [1:0] FUNC_NOP     = 2'd3;

    localparam logic [1:0] LVL_LOW  = 2'd0;
    localparam logic [1:0] LVL_MID  = 2'd1;
    localparam logic [1:0] LVL_HIGH = 2'd2;

    typedef logic [ID_BITS-1:0] t_id;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [7:0]         t_ext_id;
    typedef logic [1:0]         t_level;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] task_id;
        logic [1:0] task_priority;
    } t_req;

    typedef struct packed {
        logic       running_valid;
        logic [7:0] running_id;
        logic [1:0] running_level;
        logic       overflow;
    } t_rsp;

    typedef struct packed {
        logic push;
        logic pop;
        t_id  data;
    } t_q_ctrl;

    typedef struct packed {
        t_cnt count;
        t_id  head;
    } t_q_stat;
endpackage
`default_nettype wire

>>> src/tlps_req_if.sv
// Request channel: valid, ready and the request payload.
`default_nettype none
interface tlps_req_if;
    logic            valid;
    logic            ready;
    tlps_pkg::t_req  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/tlps_rsp_if.sv
// Response channel: valid, ready and the response payload.
`default_nettype none
interface tlps_rsp_if;
    logic            valid;
    logic            ready;
    tlps_pkg::t_rsp  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/tlps_cell.sv
// One storage cell of a ready queue chain.
`default_nettype none
module tlps_cell (
    input  wire logic          i_clk,
    input  wire logic          i_shift,
    input  wire logic          i_load,
    input  wire tlps_pkg::t_id i_load_data,
    input  wire tlps_pkg::t_id i_next_data,
    output      tlps_pkg::t_id o_data
);
    tlps_pkg::t_id r_data;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_load_data;
        end else if (i_shift) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;
endmodule
`default_nettype wire

>>> src/tlps_queue.sv
// Ready queue: a chain of cells shifting toward the head, with a fill count.
`default_nettype none
module tlps_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tlps_pkg::t_q_ctrl i_ctrl,
    output      tlps_pkg::t_q_stat o_stat
);
    localparam int DEPTH = tlps_pkg::QUEUE_DEPTH;

    tlps_pkg::t_cnt r_count;
    tlps_pkg::t_cnt n_count;
    tlps_pkg::t_cnt wr_pos;
    logic           wr_en;
    tlps_pkg::t_id  cell_q [DEPTH];

    always_comb begin
        wr_pos  = i_ctrl.pop ? (r_count - tlps_pkg::t_cnt'(1)) : r_count;
        wr_en   = i_ctrl.push && (i_ctrl.pop || (r_count != tlps_pkg::t_cnt'(DEPTH)));
        n_count = r_count;
        if (wr_en && !i_ctrl.pop) begin
            n_count = r_count + tlps_pkg::t_cnt'(1);
        end else if (i_ctrl.pop && !wr_en) begin
            n_count = r_count - tlps_pkg::t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        tlps_pkg::t_id next_data;
        if (i < DEPTH - 1) begin : g_mid
            assign next_data = cell_q[i+1];
        end else begin : g_last
            assign next_data = cell_q[i];
        end
        tlps_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (i_ctrl.pop),
            .i_load      (wr_en && (wr_pos == tlps_pkg::t_cnt'(i))),
            .i_load_data (i_ctrl.data),
            .i_next_data (next_data),
            .o_data      (cell_q[i])
        );
    end

    assign o_stat.count = r_count;
    assign o_stat.head  = cell_q[0];
endmodule
`default_nettype wire

>>> src/three_level_priority_scheduler_unit.sv
// Top level of the three-level preemptive priority scheduler.
//
//   port     dir  handshake     carries
//   i_req    in   valid/ready   func, task_id, task_priority
//   o_rsp    out  valid/ready   running_valid, running_id, running_level, overflow
//
// Each request passes first through the idle state, which applies the init or
// create push, then the schedule state, which picks, pops and pushes back the
// preempted task. The queues are cell chains, so a pop and a push into one
// queue fit in the same cycle. A new request is taken while a response still
// waits in the output register; the schedule state holds until that register
// is free. Synchronous reset empties all queues and clears the running slot.
`default_nettype none
module three_level_priority_scheduler_unit (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    tlps_req_if.sink   i_req,
    tlps_rsp_if.source o_rsp
);
    localparam logic S_IDLE  = 1'b0;
    localparam logic S_SCHED = 1'b1;
    localparam int   NL      = tlps_pkg::NUM_LEVELS;

    logic                r_state;
    logic                r_timeout;
    logic                r_nop;
    logic                r_ovf_a;
    logic                r_run_valid;
    tlps_pkg::t_id       r_run_id;
    tlps_pkg::t_level    r_run_level;
    logic                r_rsp_valid;
    tlps_pkg::t_rsp      r_rsp;

    tlps_pkg::t_q_ctrl   q_ctrl [NL];
    tlps_pkg::t_q_stat   q_stat [NL];

    logic                accept;
    logic                fire;
    logic [NL-1:0]       push_a;
    tlps_pkg::t_id       data_a;
    logic                ovf_a;
    tlps_pkg::t_level    floor_lvl;
    logic [NL-1:0]       have;
    logic                pick;
    tlps_pkg::t_level    pick_lvl;
    logic                push_b;
    logic                ovf_b;
    tlps_pkg::t_rsp      n_rsp;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign fire        = (r_state == S_SCHED) && (!r_rsp_valid || o_rsp.ready);

    always_comb begin
        push_a = '0;
        data_a = '0;
        case (i_req.payload.func)
            tlps_pkg::FUNC_INIT: begin
                push_a[tlps_pkg::LVL_LOW] = 1'b1;
            end
            tlps_pkg::FUNC_CREATE: begin
                data_a = tlps_pkg::t_id'(i_req.payload.task_id);
                if (i_req.payload.task_priority == tlps_pkg::LVL_MID) begin
                    push_a[tlps_pkg::LVL_MID] = 1'b1;
                end else if (i_req.payload.task_priority == tlps_pkg::LVL_HIGH) begin
                    push_a[tlps_pkg::LVL_HIGH] = 1'b1;
                end
            end
            default: begin
                push_a = '0;
            end
        endcase
        ovf_a = 1'b0;
        for (int l = 0; l < NL; l++) begin
            if (push_a[l] && (q_stat[l].count == tlps_pkg::t_cnt'(tlps_pkg::QUEUE_DEPTH))) begin
                ovf_a = 1'b1;
            end
        end
    end

    always_comb begin
        if (!r_run_valid) begin
            floor_lvl = tlps_pkg::LVL_LOW;
        end else if (r_timeout) begin
            floor_lvl = r_run_level;
        end else begin
            floor_lvl = r_run_level + tlps_pkg::t_level'(1);
        end
        have[2] = (q_stat[2].count != '0) && (floor_lvl <= tlps_pkg::LVL_HIGH);
        have[1] = (q_stat[1].count != '0) && (floor_lvl <= tlps_pkg::LVL_MID);
        have[0] = (q_stat[0].count != '0) && (floor_lvl == tlps_pkg::LVL_LOW);
        pick    = (|have) && !r_nop;
        if (have[2]) begin
            pick_lvl = tlps_pkg::LVL_HIGH;
        end else if (have[1]) begin
            pick_lvl = tlps_pkg::LVL_MID;
        end else begin
            pick_lvl = tlps_pkg::LVL_LOW;
        end
        push_b = pick && r_run_valid;
        ovf_b  = push_b && (r_run_level != pick_lvl)
                 && (q_stat[r_run_level].count == tlps_pkg::t_cnt'(tlps_pkg::QUEUE_DEPTH));
    end

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            if (r_state == S_IDLE) begin
                q_ctrl[l].push = accept && push_a[l];
                q_ctrl[l].pop  = 1'b0;
                q_ctrl[l].data = data_a;
            end else begin
                q_ctrl[l].push = fire && push_b && (r_run_level == tlps_pkg::t_level'(l));
                q_ctrl[l].pop  = fire && pick && (pick_lvl == tlps_pkg::t_level'(l));
                q_ctrl[l].data = r_run_id;
            end
        end
    end

    for (genvar l = 0; l < NL; l++) begin : g_queue
        tlps_queue u_queue (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (q_ctrl[l]),
            .o_stat  (q_stat[l])
        );
    end

    always_comb begin
        n_rsp.overflow = r_ovf_a | ovf_b;
        if (pick) begin
            n_rsp.running_valid = 1'b1;
            n_rsp.running_id    = tlps_pkg::t_ext_id'(q_stat[pick_lvl].head);
            n_rsp.running_level = pick_lvl;
        end else if (r_run_valid) begin
            n_rsp.running_valid = 1'b1;
            n_rsp.running_id    = tlps_pkg::t_ext_id'(r_run_id);
            n_rsp.running_level = r_run_level;
        end else begin
            n_rsp.running_valid = 1'b0;
            n_rsp.running_id    = '0;
            n_rsp.running_level = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run_valid <= 1'b0;
            r_run_id    <= '0;
            r_run_level <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SCHED;
                    end
                end
                S_SCHED: begin
                    if (fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (fire && pick) begin
                r_run_valid <= 1'b1;
                r_run_id    <= q_stat[pick_lvl].head;
                r_run_level <= pick_lvl;
            end
            if (fire) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_timeout <= (i_req.payload.func == tlps_pkg::FUNC_TIMEOUT);
            r_nop     <= (i_req.payload.func == tlps_pkg::FUNC_NOP);
            r_ovf_a   <= ovf_a;
        end
        if (fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;
endmodule
`default_nettype wire

>>> tb/three_level_priority_scheduler_unit_tb.sv
// Testbench for the three-level priority scheduler: random and directed requests.
`timescale 1ns / 1ps
module three_level_priority_scheduler_unit_tb;

    localparam int RANDOM_REQS = 1050;
    localparam int STALL_LIMIT = 5000;

    class run_slot_predictor;
        tlps_pkg::t_id    ready_q[tlps_pkg::NUM_LEVELS][$];
        tlps_pkg::t_id    cur_id;
        tlps_pkg::t_level cur_level;
        logic             cur_valid;
        tlps_pkg::t_rsp   expected_rsp[$];
        int unsigned      mismatches;

        function void clear();
            foreach (ready_q[l]) ready_q[l].delete();
            cur_id       = '0;
            cur_level    = tlps_pkg::LVL_LOW;
            cur_valid    = 1'b0;
            expected_rsp.delete();
            mismatches   = 0;
        endfunction

        function bit enqueue(int lvl, tlps_pkg::t_id id);
            if (ready_q[lvl].size() >= tlps_pkg::QUEUE_DEPTH) return 1'b1;
            ready_q[lvl] = {ready_q[lvl], id};
            return 1'b0;
        endfunction

        function bit dispatch(bit on_timeout);
            int            lvl_floor;
            int            lvl;
            tlps_pkg::t_id taken;
            bit            dropped;
            dropped = 1'b0;
            if (!cur_valid) lvl_floor = 0;
            else if (on_timeout) lvl_floor = int'(cur_level);
            else lvl_floor = int'(cur_level) + 1;
            lvl = tlps_pkg::NUM_LEVELS - 1;
            while (lvl >= lvl_floor && ready_q[lvl].size() == 0) lvl--;
            if (lvl < lvl_floor) return 1'b0;
            taken = ready_q[lvl].pop_front();
            if (cur_valid) dropped = enqueue(int'(cur_level), cur_id);
            cur_id    = taken;
            cur_level = tlps_pkg::t_level'(lvl);
            cur_valid = 1'b1;
            return dropped;
        endfunction

        function void note_request(tlps_pkg::t_req r);
            tlps_pkg::t_rsp e;
            bit             ovf;
            ovf = 1'b0;
            case (r.func)
                tlps_pkg::FUNC_INIT: begin
                    ovf |= enqueue(int'(tlps_pkg::LVL_LOW), '0);
                    ovf |= dispatch(1'b0);
                end
                tlps_pkg::FUNC_CREATE: begin
                    if (r.task_priority == tlps_pkg::LVL_MID ||
                        r.task_priority == tlps_pkg::LVL_HIGH)
                        ovf |= enqueue(int'(r.task_priority), tlps_pkg::t_id'(r.task_id));
                    ovf |= dispatch(1'b0);
                end
                tlps_pkg::FUNC_TIMEOUT: begin
                    ovf |= dispatch(1'b1);
                end
                default: begin
                end
            endcase
            e.running_valid = cur_valid;
            e.running_id    = cur_valid ? tlps_pkg::t_ext_id'(cur_id) : '0;
            e.running_level = cur_valid ? cur_level : tlps_pkg::LVL_LOW;
            e.overflow      = ovf;
            expected_rsp = {expected_rsp, e};
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v) begin
                $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_response(tlps_pkg::t_rsp got);
            tlps_pkg::t_rsp e;
            if (expected_rsp.size() == 0) begin
                $error("response with no request pending: %p", got);
                mismatches++;
                return;
            end
            e = expected_rsp.pop_front();
            compare_field("running_valid", e.running_valid, got.running_valid);
            compare_field("running_id", e.running_id, got.running_id);
            compare_field("running_level", e.running_level, got.running_level);
            compare_field("overflow", e.overflow, got.overflow);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   stall_pct;
    int   quiet_cycles;

    run_slot_predictor sched = new();

    tlps_req_if req_if();
    tlps_rsp_if rsp_if();

    three_level_priority_scheduler_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) sched.check_response(rsp_if.payload);
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_request(input tlps_pkg::t_req r);
        if ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        sched.note_request(r);
    endtask

    task automatic issue(input logic [1:0] func, input logic [7:0] id, input logic [1:0] prio);
        tlps_pkg::t_req r;
        r.func          = func;
        r.task_id       = id;
        r.task_priority = prio;
        send_request(r);
    endtask

    task automatic issue_random(input int n);
        int         pick;
        int         create_pct;
        logic [1:0] prio;
        create_pct = (n < RANDOM_REQS / 2) ? 12 : 40;
        pick = $urandom_range(99);
        if (pick < create_pct) begin
            if ($urandom_range(9) == 0) prio = $urandom_range(1) ? 2'd3 : tlps_pkg::LVL_LOW;
            else prio = $urandom_range(1) ? tlps_pkg::LVL_HIGH : tlps_pkg::LVL_MID;
            issue(tlps_pkg::FUNC_CREATE, 8'($urandom_range(255)), prio);
        end else if (pick < create_pct + 6) begin
            issue(tlps_pkg::FUNC_INIT, 8'($urandom_range(255)), 2'($urandom_range(3)));
        end else if (pick < create_pct + 10) begin
            issue(tlps_pkg::FUNC_NOP, 8'($urandom_range(255)), 2'($urandom_range(3)));
        end else begin
            issue(tlps_pkg::FUNC_TIMEOUT, 8'($urandom_range(255)), 2'($urandom_range(3)));
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        quiet_cycles   = 0;
        sched.clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(tlps_pkg::FUNC_TIMEOUT, 8'h00, tlps_pkg::LVL_LOW);
        issue(tlps_pkg::FUNC_NOP, 8'hFF, 2'd3);
        issue(tlps_pkg::FUNC_CREATE, 8'h12, tlps_pkg::LVL_LOW);
        issue(tlps_pkg::FUNC_CREATE, 8'h34, 2'd3);
        issue(tlps_pkg::FUNC_INIT, 8'h00, tlps_pkg::LVL_LOW);
        issue(tlps_pkg::FUNC_CREATE, 8'hFF, tlps_pkg::LVL_MID);
        issue(tlps_pkg::FUNC_CREATE, 8'hAA, tlps_pkg::LVL_HIGH);
        issue(tlps_pkg::FUNC_TIMEOUT, 8'h00, tlps_pkg::LVL_LOW);
        issue(tlps_pkg::FUNC_CREATE, 8'h55, tlps_pkg::LVL_HIGH);
        issue(tlps_pkg::FUNC_TIMEOUT, 8'hFF, tlps_pkg::LVL_HIGH);
        issue(tlps_pkg::FUNC_NOP, 8'h00, tlps_pkg::LVL_LOW);
        issue(tlps_pkg::FUNC_INIT, 8'hFF, 2'd3);
        for (int k = 0; k < 16; k++) issue(tlps_pkg::FUNC_CREATE, 8'(8'h80 + k), tlps_pkg::LVL_MID);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            case (n * 4 / RANDOM_REQS)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 60;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 60;
                end
                default: begin
                    send_idle_pct = 37;
                    stall_pct     = 37;
                end
            endcase
            issue_random(n);
        end
        req_if.valid <= 1'b0;

        while (sched.expected_rsp.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sched.mismatches == 0 && sched.expected_rsp.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
